>>> hdl/bmrf_pkg.sv
// shared types, codes and constants of the banked matrix register file
package bmrf_pkg;

  // fixed geometry of the 256-bit layout
  localparam int BankGroups = 4;
  localparam int TileRegs   = 16;
  localparam int RowsPerReg = 8;
  localparam int TileBanks  = 2 * BankGroups;
  localparam int TileLines  = BankGroups * TileBanks * (TileRegs / BankGroups) * RowsPerReg;
  localparam int AccBanks   = 4;
  localparam int AccDepth   = BankGroups * AccBanks * (TileRegs * 2) * 2;
  localparam int AccAddrW   = $clog2(AccDepth);
  localparam int DefRowBytes = 32;

  // request kinds
  localparam logic [2:0] KIND_TILE_WR  = 3'd0;
  localparam logic [2:0] KIND_TILE_RD  = 3'd1;
  localparam logic [2:0] KIND_ACC_WR   = 3'd2;
  localparam logic [2:0] KIND_ACC_RD   = 3'd3;
  localparam logic [2:0] KIND_CLAIM_WP = 3'd4;
  localparam logic [2:0] KIND_CLAIM_RP = 3'd5;
  localparam logic [2:0] KIND_FREE_WP  = 3'd6;
  localparam logic [2:0] KIND_FREE_RP  = 3'd7;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BUSY    = 2'd1;
  localparam logic [1:0] ST_BAD_REG = 2'd2;

  typedef struct packed {
    logic [2:0]  kind;
    logic [4:0]  reg_index;
    logic [1:0]  bank_index;
    logic [2:0]  row_index;
    logic [4:0]  offset;
    logic [31:0] write_data;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [1:0]  status;
  } rsp_t;

  // decoded control from the address map
  typedef struct packed {
    logic       tile_we;
    logic       tile_rd;
    logic       acc_we;
    logic       acc_rd;
    logic       bad_reg;
    logic       flag_op;
    logic       flag_release;
    logic       flag_read_port;
    logic [1:0] flag_group;
  } ctl_t;

endpackage

>>> hdl/banked_matrix_register_file.sv
// top level of the banked matrix register file, 256-bit layout
// Takes one request per clock: a request is accepted at a rising edge with start high
// and busy low, and its result shows on result for exactly one cycle with done high,
// in the cycle after acceptance. busy is high only while rst is held. Reads use
// the registered read port of the tile and accumulator rams; reads see every write
// accepted earlier, including the one just before. The result cannot be stalled, so
// the receiver must take it in the cycle done is high. Tile storage holds
// 1024*ROW_BYTES bytes, accumulator storage 1024 words; neither is cleared by reset,
// and a read of an entry never written returns an unspecified value.
module banked_matrix_register_file import bmrf_pkg::*; #(
  parameter int ROW_BYTES = DefRowBytes
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t request,
  output logic busy,
  output logic done,
  output rsp_t result
);

  localparam int TAddrW = $clog2(TileLines * ROW_BYTES);

  logic              accept;
  ctl_t              ctl;
  logic [TAddrW-1:0] tile_addr;
  logic [AccAddrW-1:0] acc_addr;
  logic [7:0]        tile_rdata;
  logic [31:0]       acc_rdata;
  logic [1:0]        flag_status;
  logic [1:0]        status_next;

  // result stage registers
  logic              sel_tile;
  logic              sel_acc;
  logic [1:0]        status;

  // no access can stall, so only reset holds requests off
  assign busy   = rst;
  assign accept = start && !busy;

  // address mapping and kind decode
  bmrf_map #(.ROW_BYTES(ROW_BYTES)) u_map (
    .fire      (accept),
    .request   (request),
    .ctl       (ctl),
    .tile_addr (tile_addr),
    .acc_addr  (acc_addr)
  );

  // byte wide tile storage
  bmrf_ram #(.WIDTH(8), .DEPTH(TileLines * ROW_BYTES)) u_tile_ram (
    .clk   (clk),
    .we    (ctl.tile_we),
    .addr  (tile_addr),
    .wdata (request.write_data[7:0]),
    .rdata (tile_rdata)
  );

  // word wide accumulator storage
  bmrf_ram #(.WIDTH(32), .DEPTH(AccDepth)) u_acc_ram (
    .clk   (clk),
    .we    (ctl.acc_we),
    .addr  (acc_addr),
    .wdata (request.write_data),
    .rdata (acc_rdata)
  );

  // port claim and release flags
  bmrf_flags u_flags (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .flag_status (flag_status)
  );

  // status is known at acceptance; data comes from the ram in the following cycle
  always_comb begin
    if (request.kind[2]) begin
      status_next = flag_status;
    end else if (ctl.bad_reg) begin
      status_next = ST_BAD_REG;
    end else begin
      status_next = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done     <= 1'b0;
      sel_tile <= 1'b0;
      sel_acc  <= 1'b0;
    end else begin
      done     <= accept;
      sel_tile <= ctl.tile_rd;
      sel_acc  <= ctl.acc_rd;
    end
    status <= status_next;
  end

  // pick the read data of the ram that served a read, zero for everything else
  always_comb begin
    result.status = status;
    if (sel_tile) begin
      result.read_data = {24'd0, tile_rdata};
    end else if (sel_acc) begin
      result.read_data = acc_rdata;
    end else begin
      result.read_data = 32'd0;
    end
  end

endmodule

>>> hdl/bmrf_ram.sv
// generic single-port synchronous ram with registered read
module bmrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> hdl/bmrf_map.sv
// register, bank, row and offset to physical address mapping and request decode
module bmrf_map import bmrf_pkg::*; #(
  parameter int ROW_BYTES = DefRowBytes
) (
  input  logic                                   fire,
  input  req_t                                   request,
  output ctl_t                                   ctl,
  output logic [$clog2(TileLines*ROW_BYTES)-1:0] tile_addr,
  output logic [AccAddrW-1:0]                    acc_addr
);

  localparam int TAddrW = $clog2(TileLines * ROW_BYTES);
  localparam int ByteW  = $clog2(ROW_BYTES);
  localparam logic [6:0] RowBytesC = 7'(ROW_BYTES);

  logic       is_tile;
  logic [1:0] tgroup;
  logic [2:0] tbank;
  logic [4:0] tentry;
  logic [6:0] byte_sel;
  logic [1:0] agroup;
  logic [9:0] tline;

  always_comb begin
    is_tile = ~request.reg_index[4];
    tgroup  = request.reg_index[1:0];
    tbank   = {1'b0, request.bank_index} + {1'b0, request.reg_index[3:2]};
    tentry  = {request.reg_index[3:2], request.row_index};
    tline   = {tgroup, tbank, tentry};

    // offset wraps modulo the row size for rows of at least 7 bytes: at most four subtractions for a 5-bit offset
    byte_sel = {2'b00, request.offset};
    for (int i = 0; i < 4; i++) begin
      if (byte_sel >= RowBytesC) begin
        byte_sel = byte_sel - RowBytesC;
      end
    end

    tile_addr = TAddrW'(TAddrW'(tline) * TAddrW'(ROW_BYTES)) + TAddrW'(byte_sel[ByteW-1:0]);

    agroup   = request.reg_index[1:0] + request.row_index[1:0];
    acc_addr = {agroup, request.bank_index, request.reg_index[3:0],
                request.row_index[2], request.offset[0]};

    ctl = '0;
    ctl.tile_we        = fire && request.kind == KIND_TILE_WR && is_tile;
    ctl.tile_rd        = fire && request.kind == KIND_TILE_RD && is_tile;
    ctl.acc_we         = fire && request.kind == KIND_ACC_WR && !is_tile;
    ctl.acc_rd         = fire && request.kind == KIND_ACC_RD && !is_tile;
    ctl.bad_reg        = !request.kind[2] && (request.kind[1] != request.reg_index[4]);
    ctl.flag_op        = fire && request.kind[2];
    ctl.flag_release   = request.kind[1];
    ctl.flag_read_port = request.kind[0];
    ctl.flag_group     = is_tile ? tgroup : agroup;
  end

endmodule

>>> hdl/bmrf_flags.sv
// per bank group write-port and read-port busy flags
module bmrf_flags import bmrf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  ctl_t       ctl,
  output logic [1:0] flag_status
);

  logic [BankGroups-1:0] write_port_busy;
  logic [BankGroups-1:0] read_port_busy;
  logic [BankGroups-1:0] sel;
  logic                  taken;

  always_comb begin
    sel   = BankGroups'(1) << ctl.flag_group;
    taken = ctl.flag_read_port ? |(read_port_busy & sel) : |(write_port_busy & sel);
    flag_status = (!ctl.flag_release && taken) ? ST_BUSY : ST_OK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_port_busy <= '0;
      read_port_busy  <= '0;
    end else if (ctl.flag_op) begin
      if (ctl.flag_read_port) begin
        read_port_busy <= ctl.flag_release ? (read_port_busy & ~sel) : (read_port_busy | sel);
      end else begin
        write_port_busy <= ctl.flag_release ? (write_port_busy & ~sel) : (write_port_busy | sel);
      end
    end
  end

endmodule

>>> hdl/bmrf_checker.sv
// port-level checker for the banked matrix register file, bound to the top level
module bmrf_checker import bmrf_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input req_t request,
  input logic busy,
  input logic done,
  input rsp_t result
);

  // every accepted request gives a result in the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> done)
    else $error("accepted request gave no result");

  // no result without a request
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy))
    else $error("result without a request");

  // failed requests return zero data
  a_zero_on_fail: assert property (@(posedge clk) disable iff (rst)
    done && result.status != ST_OK |-> result.read_data == 32'd0)
    else $error("nonzero data on a failed request");

  // bad register status exactly when the register class does not fit the kind
  a_bad_reg: assert property (@(posedge clk) disable iff (rst)
    done |-> ((result.status == ST_BAD_REG) ==
              $past(!request.kind[2] && (request.kind[1] != request.reg_index[4]))))
    else $error("register class status mismatch");

  // busy status only answers a claim
  a_busy_claim: assert property (@(posedge clk) disable iff (rst)
    done && result.status == ST_BUSY |-> $past(request.kind[2] && !request.kind[1]))
    else $error("port busy status on a request that is not a claim");

endmodule

bind banked_matrix_register_file bmrf_checker u_bmrf_checker (.*);
